@@ rtl/scfc_pkg.sv @@
// Shared types, constants and the CRC32C byte update for the sampled file checker.
package scfc_pkg;

    // CRC32C, reflected form
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Widths of the stream and configuration fields
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned CRC_W    = 32;
    localparam int unsigned AMOUNT_W = 32;
    localparam int unsigned POS_W    = 64;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W    = 32;

    // Work queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_AMOUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED      = 2'd2;

    // Reset values of the configuration registers
    localparam logic [AMOUNT_W-1:0] AMOUNT_RESET   = 32'd1024;
    localparam logic [CRC_W-1:0]    EXPECTED_RESET = 32'd0;

    typedef enum logic [1:0] {
        MODE_FULL   = 2'd0,
        MODE_FIRST  = 2'd1,
        MODE_PERIOD = 2'd2,
        MODE_NONE   = 2'd3
    } t_sample_mode;

    // One classified byte on its way to the CRC engine
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              take;
        logic              last;
    } t_work_item;

    // One byte into the reflected CRC register, bit at a time
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [DATA_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-DATA_W){1'b0}}, b};
        for (int i = 0; i < DATA_W; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
        end
        return c;
    endfunction

endpackage

@@ rtl/scfc_front.sv @@
// Front end: tracks the file offset and decides which bytes are hashed.
module scfc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [scfc_pkg::DATA_W-1:0]     i_data,
    input  logic                            i_last,
    input  logic                            i_space,
    input  scfc_pkg::t_sample_mode          i_mode,
    input  logic [scfc_pkg::AMOUNT_W-1:0]   i_amount,
    output logic                            o_push,
    output scfc_pkg::t_work_item            o_item
);
    import scfc_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_next_sample, n_next_sample;
    logic             take;
    logic             due;
    logic [POS_W-1:0] stride;
    logic [POS_W:0]   next_sum;

    assign o_push = i_valid && i_space;

    // Period mode: next sampled offset, saturating at all ones
    assign due      = r_pos >= r_next_sample;
    assign stride   = (i_amount == '0) ? POS_W'(1) : {{(POS_W-AMOUNT_W){1'b0}}, i_amount};
    assign next_sum = {1'b0, r_pos} + {1'b0, stride};

    // Byte selection
    always_comb begin
        unique case (i_mode)
            MODE_FULL:   take = 1'b1;
            MODE_FIRST:  take = r_pos < {{(POS_W-AMOUNT_W){1'b0}}, i_amount};
            MODE_PERIOD: take = due;
            MODE_NONE:   take = 1'b0;
            default:     take = 1'b0;
        endcase
    end

    assign o_item.data = i_data;
    assign o_item.take = take;
    assign o_item.last = i_last;

    // Offset bookkeeping, cleared at the end of each file
    always_comb begin
        n_pos         = r_pos;
        n_next_sample = r_next_sample;
        if (o_push) begin
            if (i_last) begin
                n_pos         = '0;
                n_next_sample = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
                if (i_mode == MODE_PERIOD && due) begin
                    n_next_sample = next_sum[POS_W] ? {POS_W{1'b1}} : next_sum[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_next_sample <= '0;
        end else begin
            r_pos         <= n_pos;
            r_next_sample <= n_next_sample;
        end
    end

endmodule

@@ rtl/scfc_queue.sv @@
// Short work queue that decouples the classifier from the CRC engine.
module scfc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  scfc_pkg::t_work_item  i_item,
    input  logic                  i_pop,
    output logic                  o_space,
    output logic                  o_nonempty,
    output scfc_pkg::t_work_item  o_item
);
    import scfc_pkg::*;

    t_work_item            r_mem [QDEPTH];
    logic [QPTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]       r_count, n_count;

    assign o_space    = r_count != (QPTR_W+1)'(QDEPTH);
    assign o_nonempty = r_count != '0;
    assign o_item     = r_mem[r_rd_ptr];

    // Occupancy
    always_comb begin
        n_count = r_count;
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_item;
    end

endmodule

@@ rtl/scfc_back.sv @@
// Back end: CRC32C engine and result register.
module scfc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_nonempty,
    input  scfc_pkg::t_work_item          i_item,
    input  logic [scfc_pkg::CRC_W-1:0]    i_expected,
    input  logic                          i_ready,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [scfc_pkg::CRC_W-1:0]    o_crc,
    output logic                          o_match
);
    import scfc_pkg::*;

    logic [CRC_W-1:0] r_crc, n_crc;
    logic [CRC_W-1:0] upd_crc;
    logic [CRC_W-1:0] fin_crc;
    logic             r_out_valid;
    logic [CRC_W-1:0] r_out_crc;
    logic             r_out_match;
    logic             slot_free;

    // A final byte waits only while the result register is still held
    assign slot_free = !r_out_valid || i_ready;
    assign o_pop     = i_nonempty && (!i_item.last || slot_free);

    assign upd_crc = i_item.take ? crc_byte(r_crc, i_item.data) : r_crc;
    assign fin_crc = ~upd_crc;

    // Running register, restarted after each file
    always_comb begin
        n_crc = r_crc;
        if (o_pop) n_crc = i_item.last ? CRC_INIT : upd_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_crc <= n_crc;
            if (o_pop && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_out_crc   <= fin_crc;
            r_out_match <= fin_crc == i_expected;
        end
    end

    assign o_valid = r_out_valid;
    assign o_crc   = r_out_crc;
    assign o_match = r_out_match;

endmodule

@@ rtl/sampled_crc32c_file_checker_top.sv @@
// Top level of the sampled CRC32C file checker.
//
//  channel   dir  handshake                   word
//  s_axis    in   s_axis_tvalid/tready        tdata[7:0] data_byte, tlast final_byte
//  m_axis    out  m_axis_tvalid/tready        tdata[31:0] crc_value, tuser[0] crc_matches
//  cfg       in   i_cfg_we (always taken)     i_cfg_index, i_cfg_wdata
//
// One byte per cycle sustained; the CRC engine folds a whole byte each cycle.
// A checksum is registered in the result word once its final byte has passed the queue.
// A held result stalls the engine only on the next final byte; the four-entry
// queue then fills and s_axis_tready drops.
// Synchronous active-low reset; no clearing pass, input is taken right after.
module sampled_crc32c_file_checker_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [7:0] data_byte
    input  logic                               s_axis_tlast,   // final_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [31:0]                        m_axis_tdata,   // [31:0] crc_value
    output logic [0:0]                         m_axis_tuser,   // [0] crc_matches
    input  logic                               i_cfg_we,
    input  logic [scfc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [scfc_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import scfc_pkg::*;

    t_sample_mode      r_mode;
    logic [AMOUNT_W-1:0] r_amount;
    logic [CRC_W-1:0]  r_expected;

    logic        push, pop, space, nonempty, match;
    t_work_item  front_item, head_item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_FIRST;
            r_amount   <= AMOUNT_RESET;
            r_expected <= EXPECTED_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SAMPLE_MODE:   r_mode     <= t_sample_mode'(i_cfg_wdata[1:0]);
                REG_SAMPLE_AMOUNT: r_amount   <= i_cfg_wdata[AMOUNT_W-1:0];
                REG_EXPECTED:      r_expected <= i_cfg_wdata[CRC_W-1:0];
                default:           ;
            endcase
        end
    end

    assign s_axis_tready = space;

    scfc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_space  (space),
        .i_mode   (r_mode),
        .i_amount (r_amount),
        .o_push   (push),
        .o_item   (front_item)
    );

    scfc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (front_item),
        .i_pop      (pop),
        .o_space    (space),
        .o_nonempty (nonempty),
        .o_item     (head_item)
    );

    scfc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_item     (head_item),
        .i_expected (r_expected),
        .i_ready    (m_axis_tready),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .o_crc      (m_axis_tdata),
        .o_match    (match)
    );

    assign m_axis_tuser = match;

endmodule

@@ rtl/scfc_checker.sv @@
// Port-level checks for the sampled CRC32C file checker, bound to the top level.
module scfc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // No result comes out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Input backpressure only arises behind a pending result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    // Ready never drops on its own: an idle output side is always followed by input ready
    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |=> s_axis_tready)
        else $error("input stalled after output was idle");

endmodule

bind sampled_crc32c_file_checker_top scfc_checker u_scfc_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the sampled CRC32C file checker: byte streams, config phases, checksums.
module testbench;
    import scfc_pkg::*;

    typedef logic [7:0] file_bytes_t[$];

    // Expected checksums of the files streamed so far, oldest first
    class checksum_tracker;
        localparam logic [31:0] CASTAGNOLI_REFLECTED = 32'h82F6_3B78;

        typedef struct {
            logic [31:0] crc;
            logic [63:0] pos;
            logic [63:0] next_pos;
        } file_state_t;

        typedef struct {
            logic [31:0] crc;
            logic        match;
        } checksum_t;

        t_sample_mode mode;
        logic [31:0]  amount;
        logic [31:0]  expect_crc;
        file_state_t  live;
        checksum_t    pending_checksums[$];
        int unsigned  fail_count;

        function new();
            mode       = MODE_FIRST;
            amount     = AMOUNT_RESET;
            expect_crc = EXPECTED_RESET;
            live       = fresh();
            fail_count = 0;
        endfunction

        function file_state_t fresh();
            file_state_t st;
            st.crc      = '1;
            st.pos      = '0;
            st.next_pos = '0;
            return st;
        endfunction

        function void set_config(t_sample_mode m, logic [31:0] n, logic [31:0] e);
            mode       = m;
            amount     = n;
            expect_crc = e;
        endfunction

        // One byte of a file: decide whether it is hashed, then fold it in
        function file_state_t advance(file_state_t st, t_sample_mode m, logic [31:0] n,
                                      logic [7:0] b);
            logic        take;
            logic [63:0] stride;
            logic [31:0] c;
            take   = 1'b0;
            stride = (n == 0) ? 64'd1 : {32'd0, n};
            case (m)
                MODE_FULL:  take = 1'b1;
                MODE_FIRST: take = st.pos < {32'd0, n};
                MODE_PERIOD: begin
                    if (st.pos >= st.next_pos) begin
                        take = 1'b1;
                        // saturates instead of wrapping
                        if (st.pos > ~stride) st.next_pos = '1;
                        else st.next_pos = st.pos + stride;
                    end
                end
                default: take = 1'b0;
            endcase
            if (take) begin
                c = st.crc ^ {24'd0, b};
                for (int k = 0; k < 8; k++) begin
                    if (c[0]) c = (c >> 1) ^ CASTAGNOLI_REFLECTED;
                    else c = c >> 1;
                end
                st.crc = c;
            end
            st.pos = st.pos + 64'd1;
            return st;
        endfunction

        // Checksum a whole file would get under a given setting
        function logic [31:0] predict_file(t_sample_mode m, logic [31:0] n, file_bytes_t fb);
            file_state_t st;
            st = fresh();
            foreach (fb[k]) st = advance(st, m, n, fb[k]);
            return ~st.crc;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            checksum_t r;
            live = advance(live, mode, amount, b);
            if (last) begin
                r.crc   = ~live.crc;
                r.match = (r.crc == expect_crc);
                pending_checksums.push_back(r);
                live = fresh();
            end
        endfunction

        function void check_checksum(logic [31:0] crc, logic match);
            checksum_t want;
            if (pending_checksums.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected checksum word: crc %08h match %0b", crc, match);
                return;
            end
            want = pending_checksums.pop_front();
            if (crc !== want.crc || match !== want.match) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("checksum mismatch: crc exp %08h got %08h, match exp %0b got %0b",
                             want.crc, crc, want.match, match);
            end
        endfunction

        function int unsigned pending();
            return pending_checksums.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // [7:0] data_byte
    logic                 s_axis_tlast;   // final_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [31:0]          m_axis_tdata;   // [31:0] crc_value
    logic [0:0]           m_axis_tuser;   // [0] crc_matches
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;

    checksum_tracker sb;
    bit              calm;
    int unsigned     bytes_sent;

    sampled_crc32c_file_checker_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("sampled_crc32c_file_checker_top test failed");
        $finish;
    end

    // Both handshakes are observed here, on the values seen at the edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) sb.check_checksum(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    // Result side: ready with random stall bursts
    initial begin
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_file(input file_bytes_t fb);
        foreach (fb[k]) send_byte(fb[k], k == fb.size() - 1);
    endtask

    // Stop sending, let every checksum come back, then let the pipe settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic program_regs(input t_sample_mode mode, input logic [31:0] amount,
                                input logic [31:0] expect_crc);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_SAMPLE_MODE;
        i_cfg_wdata <= {30'd0, mode};
        @(posedge i_clk);
        i_cfg_index <= REG_SAMPLE_AMOUNT;
        i_cfg_wdata <= amount;
        @(posedge i_clk);
        i_cfg_index <= REG_EXPECTED;
        i_cfg_wdata <= expect_crc;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_config(mode, amount, expect_crc);
    endtask

    // Config then one file, expected value set to that file's own checksum
    task automatic matched_file(input t_sample_mode mode, input logic [31:0] amount,
                                input file_bytes_t fb);
        program_regs(mode, amount, sb.predict_file(mode, amount, fb));
        send_file(fb);
        wait_drained();
    endtask

    function automatic file_bytes_t random_file();
        file_bytes_t fb;
        int unsigned roll;
        int unsigned len;
        roll = $urandom_range(0, 9);
        if (roll == 0) len = 1;
        else if (roll < 8) len = $urandom_range(1, 20);
        else len = $urandom_range(21, 60);
        repeat (len) fb.push_back(8'($urandom));
        return fb;
    endfunction

    function automatic logic [31:0] random_amount();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 5) return $urandom_range(0, 3);
        if (roll < 15) return $urandom_range(1, 24);
        if (roll < 18) return $urandom;
        return (roll == 18) ? 32'd0 : 32'hFFFF_FFFF;
    endfunction

    initial begin
        file_bytes_t  fb;
        t_sample_mode mode;
        logic [31:0]  amount;
        logic [31:0]  expect_crc;
        int unsigned  roll;
        int unsigned  nfiles;

        sb            = new();
        calm          = 1'b0;
        bytes_sent    = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_SAMPLE_MODE;
        i_cfg_wdata   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset setting (first 1024 bytes, expected zero)
        fb = '{8'h00, 8'hFF, 8'hA5};
        send_file(fb);
        wait_drained();
        // nothing hashed: checksum is zero and matches a zero expectation
        program_regs(MODE_NONE, 32'd7, 32'd0);
        fb = '{8'h5A, 8'hFF};
        send_file(fb);
        wait_drained();
        // standard check string over every byte
        fb = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
        matched_file(MODE_FULL, 32'd0, fb);
        // first-N with N of zero hashes nothing
        program_regs(MODE_FIRST, 32'd0, 32'hFFFF_FFFF);
        fb = '{8'h80, 8'h01};
        send_file(fb);
        wait_drained();
        // zero stride behaves as stride one
        fb = '{8'h12, 8'hED, 8'h00};
        matched_file(MODE_PERIOD, 32'd0, fb);
        // widest stride: only offset zero is hashed
        fb = '{8'hC3, 8'h3C, 8'hFF};
        matched_file(MODE_PERIOD, 32'hFFFF_FFFF, fb);
        // single-byte file, widest first-N limit
        program_regs(MODE_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        fb = '{8'h7F};
        send_file(fb);
        wait_drained();
        fb = '{8'hAA, 8'h55};
        matched_file(MODE_PERIOD, 32'd2, fb);

        // Random phases: a setting, then a few files under it
        bytes_sent = 0;
        while (bytes_sent < 650) begin
            if (bytes_sent >= 560) calm = 1'b1;
            mode   = t_sample_mode'($urandom_range(0, 3));
            amount = random_amount();
            fb     = random_file();
            roll   = $urandom_range(0, 9);
            if (roll < 5) expect_crc = sb.predict_file(mode, amount, fb);
            else if (roll < 7) expect_crc = 32'd0;
            else expect_crc = $urandom;
            program_regs(mode, amount, expect_crc);
            send_file(fb);
            nfiles = $urandom_range(0, 3);
            repeat (nfiles) send_file(random_file());
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("sampled_crc32c_file_checker_top test passed");
        end else begin
            $display("sampled_crc32c_file_checker_top test failed");
        end
        $finish;
    end
endmodule
